FILE: hdl/pal_pkg.sv
package pal_pkg;

    localparam int MAX_ENTRIES     = 64;
    localparam int ENTRY_WIDTH_DEF = 32;

    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

    // beat field widths
    localparam int CMD_W  = 3;
    localparam int POS_W  = 7;
    localparam int OPOS_W = 6;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 7;

    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam int IN_FIELDS_W  = POS_W + OPOS_W + VAL_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = VAL_W + STAT_W + LEN_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SWAP   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_CNT_M1,
        PTR_POS_P1,
        PTR_DEC,
        PTR_INC
    } t_ptr_op;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_POS,
        RD_OPOS,
        RD_PTR
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_UP,
        WR_DN,
        WR_POS_VAL,
        WR_POS_RD,
        WR_OPOS_TMP
    } t_wr_sel;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } t_cnt_op;

    typedef struct packed {
        logic              capture;
        t_ptr_op           ptr_op;
        t_rd_sel           rd_sel;
        t_wr_sel           wr_sel;
        logic              tmp_load;
        t_cnt_op           cnt_op;
        logic              out_load;
        logic [STAT_W-1:0] out_status;
        logic              out_rd;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             pos_lt_cnt;
        logic             pos_le_cnt;
        logic             opos_lt_cnt;
        logic             full;
        logic             pos_last;
        logic             ptr_eq_pos;
        logic             ptr_last;
        logic             out_free;
    } t_dp_stat;

endpackage

FILE: hdl/pal_dp.sv
module pal_dp #(
    parameter int ENTRY_WIDTH = pal_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [pal_pkg::CMD_W-1:0]         i_cmd,
    input  logic [pal_pkg::POS_W-1:0]         i_pos,
    input  logic [pal_pkg::OPOS_W-1:0]        i_opos,
    input  logic [pal_pkg::VAL_W-1:0]         i_val,
    input  pal_pkg::t_dp_cmd                  i_dp_cmd,
    output pal_pkg::t_dp_stat                 o_dp_stat,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [pal_pkg::OUT_TDATA_W-1:0]   o_out_data
);

    localparam int AW = pal_pkg::ADDR_W;
    localparam int CW = pal_pkg::CNT_W;
    localparam int KW = pal_pkg::CMP_W;

    logic [ENTRY_WIDTH-1:0] r_mem [pal_pkg::MAX_ENTRIES];
    logic [ENTRY_WIDTH-1:0] r_rdata;
    logic [ENTRY_WIDTH-1:0] r_tmp;

    logic [pal_pkg::CMD_W-1:0]  r_cmd;
    logic [pal_pkg::POS_W-1:0]  r_pos;
    logic [pal_pkg::OPOS_W-1:0] r_opos;
    logic [pal_pkg::VAL_W-1:0]  r_val;

    logic [AW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_count, n_count;

    logic                             r_out_valid;
    logic [pal_pkg::OUT_TDATA_W-1:0]  r_out_data;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [ENTRY_WIDTH-1:0] wr_data;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;

    logic [KW-1:0] pos_k, opos_k, cnt_k, ptr_k;
    logic [AW-1:0] pos_a, opos_a;
    logic [pal_pkg::VAL_W-1:0] rd_field;
    logic [pal_pkg::LEN_W-1:0] len_field;

    assign pos_k  = KW'(r_pos);
    assign opos_k = KW'(r_opos);
    assign cnt_k  = KW'(r_count);
    assign ptr_k  = KW'(r_ptr);
    assign pos_a  = AW'(r_pos);
    assign opos_a = AW'(r_opos);

    always_comb begin
        case (i_dp_cmd.ptr_op)
            pal_pkg::PTR_CNT_M1: n_ptr = AW'(r_count - CW'(1));
            pal_pkg::PTR_POS_P1: n_ptr = pos_a + AW'(1);
            pal_pkg::PTR_DEC:    n_ptr = r_ptr - AW'(1);
            pal_pkg::PTR_INC:    n_ptr = r_ptr + AW'(1);
            default:             n_ptr = r_ptr;
        endcase
    end

    always_comb begin
        case (i_dp_cmd.cnt_op)
            pal_pkg::CNT_INC: n_count = r_count + CW'(1);
            pal_pkg::CNT_DEC: n_count = r_count - CW'(1);
            pal_pkg::CNT_CLR: n_count = '0;
            default:          n_count = r_count;
        endcase
    end

    always_comb begin
        rd_en = 1'b1;
        case (i_dp_cmd.rd_sel)
            pal_pkg::RD_POS:  rd_addr = pos_a;
            pal_pkg::RD_OPOS: rd_addr = opos_a;
            pal_pkg::RD_PTR:  rd_addr = n_ptr;
            default: begin
                rd_en   = 1'b0;
                rd_addr = r_ptr;
            end
        endcase
    end

    always_comb begin
        wr_en = 1'b1;
        case (i_dp_cmd.wr_sel)
            pal_pkg::WR_UP: begin
                wr_addr = r_ptr + AW'(1);
                wr_data = r_rdata;
            end
            pal_pkg::WR_DN: begin
                wr_addr = r_ptr - AW'(1);
                wr_data = r_rdata;
            end
            pal_pkg::WR_POS_VAL: begin
                wr_addr = pos_a;
                wr_data = ENTRY_WIDTH'(r_val);
            end
            pal_pkg::WR_POS_RD: begin
                wr_addr = pos_a;
                wr_data = r_rdata;
            end
            pal_pkg::WR_OPOS_TMP: begin
                wr_addr = opos_a;
                wr_data = r_tmp;
            end
            default: begin
                wr_en   = 1'b0;
                wr_addr = pos_a;
                wr_data = r_tmp;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (i_dp_cmd.tmp_load) begin
            r_tmp <= r_rdata;
        end
        if (i_dp_cmd.capture) begin
            r_cmd  <= i_cmd;
            r_pos  <= i_pos;
            r_opos <= i_opos;
            r_val  <= i_val;
        end
        r_ptr <= n_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign rd_field  = i_dp_cmd.out_rd ? pal_pkg::VAL_W'(r_rdata) : '0;
    assign len_field = pal_pkg::LEN_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dp_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.out_load) begin
            r_out_data <= pal_pkg::OUT_TDATA_W'({(r_count == '0), len_field,
                                                 i_dp_cmd.out_status, rd_field});
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        o_dp_stat.cmd         = r_cmd;
        o_dp_stat.pos_lt_cnt  = pos_k < cnt_k;
        o_dp_stat.pos_le_cnt  = pos_k <= cnt_k;
        o_dp_stat.opos_lt_cnt = opos_k < cnt_k;
        o_dp_stat.full        = r_count == CW'(pal_pkg::MAX_ENTRIES);
        o_dp_stat.pos_last    = (pos_k + KW'(1)) == cnt_k;
        o_dp_stat.ptr_eq_pos  = ptr_k == pos_k;
        o_dp_stat.ptr_last    = (ptr_k + KW'(1)) == cnt_k;
        o_dp_stat.out_free    = !r_out_valid || i_out_ready;
    end

endmodule

FILE: hdl/pal_ctrl.sv
module pal_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pal_pkg::t_dp_stat  i_dp_stat,
    output pal_pkg::t_dp_cmd   o_dp_cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_EXEC    = 9'b000000010,
        S_INS     = 9'b000000100,
        S_INS_PUT = 9'b000001000,
        S_DEL     = 9'b000010000,
        S_SW1     = 9'b000100000,
        S_SW2     = 9'b001000000,
        S_SW3     = 9'b010000000,
        S_RESP    = 9'b100000000
    } t_state;

    t_state                      r_state, n_state;
    logic [pal_pkg::STAT_W-1:0]  r_status, n_status;
    logic                        r_rd_flag, n_rd_flag;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_status  = r_status;
        n_rd_flag = r_rd_flag;

        o_dp_cmd.capture    = 1'b0;
        o_dp_cmd.ptr_op     = pal_pkg::PTR_HOLD;
        o_dp_cmd.rd_sel     = pal_pkg::RD_NONE;
        o_dp_cmd.wr_sel     = pal_pkg::WR_NONE;
        o_dp_cmd.tmp_load   = 1'b0;
        o_dp_cmd.cnt_op     = pal_pkg::CNT_HOLD;
        o_dp_cmd.out_load   = 1'b0;
        o_dp_cmd.out_status = r_status;
        o_dp_cmd.out_rd     = r_rd_flag;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_dp_cmd.capture = 1'b1;
                    n_state          = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status  = pal_pkg::ST_OK;
                n_rd_flag = 1'b0;
                n_state   = S_RESP;
                case (i_dp_stat.cmd)
                    pal_pkg::CMD_READ: begin
                        if (i_dp_stat.pos_lt_cnt) begin
                            o_dp_cmd.rd_sel = pal_pkg::RD_POS;
                            n_rd_flag       = 1'b1;
                        end else begin
                            n_status = pal_pkg::ST_RANGE;
                        end
                    end
                    pal_pkg::CMD_WRITE: begin
                        if (i_dp_stat.pos_lt_cnt) begin
                            o_dp_cmd.wr_sel = pal_pkg::WR_POS_VAL;
                        end else begin
                            n_status = pal_pkg::ST_RANGE;
                        end
                    end
                    pal_pkg::CMD_INSERT: begin
                        if (!i_dp_stat.pos_le_cnt) begin
                            n_status = pal_pkg::ST_RANGE;
                        end else if (i_dp_stat.full) begin
                            n_status = pal_pkg::ST_FULL;
                        end else if (i_dp_stat.pos_lt_cnt) begin
                            // start the upward shift at the top entry
                            o_dp_cmd.ptr_op = pal_pkg::PTR_CNT_M1;
                            o_dp_cmd.rd_sel = pal_pkg::RD_PTR;
                            n_state         = S_INS;
                        end else begin
                            o_dp_cmd.wr_sel = pal_pkg::WR_POS_VAL;
                            o_dp_cmd.cnt_op = pal_pkg::CNT_INC;
                        end
                    end
                    pal_pkg::CMD_REMOVE: begin
                        if (!i_dp_stat.pos_lt_cnt) begin
                            n_status = pal_pkg::ST_RANGE;
                        end else if (i_dp_stat.pos_last) begin
                            o_dp_cmd.cnt_op = pal_pkg::CNT_DEC;
                        end else begin
                            o_dp_cmd.ptr_op = pal_pkg::PTR_POS_P1;
                            o_dp_cmd.rd_sel = pal_pkg::RD_PTR;
                            n_state         = S_DEL;
                        end
                    end
                    pal_pkg::CMD_SWAP: begin
                        if (i_dp_stat.pos_lt_cnt && i_dp_stat.opos_lt_cnt) begin
                            o_dp_cmd.rd_sel = pal_pkg::RD_POS;
                            n_state         = S_SW1;
                        end else begin
                            n_status = pal_pkg::ST_RANGE;
                        end
                    end
                    pal_pkg::CMD_CLEAR: begin
                        o_dp_cmd.cnt_op = pal_pkg::CNT_CLR;
                    end
                    default: begin
                    end
                endcase
            end
            S_INS: begin
                // move entry ptr up one place, fetch the one below
                o_dp_cmd.wr_sel = pal_pkg::WR_UP;
                if (i_dp_stat.ptr_eq_pos) begin
                    n_state = S_INS_PUT;
                end else begin
                    o_dp_cmd.ptr_op = pal_pkg::PTR_DEC;
                    o_dp_cmd.rd_sel = pal_pkg::RD_PTR;
                end
            end
            S_INS_PUT: begin
                o_dp_cmd.wr_sel = pal_pkg::WR_POS_VAL;
                o_dp_cmd.cnt_op = pal_pkg::CNT_INC;
                n_state         = S_RESP;
            end
            S_DEL: begin
                // move entry ptr down one place, fetch the one above
                o_dp_cmd.wr_sel = pal_pkg::WR_DN;
                if (i_dp_stat.ptr_last) begin
                    o_dp_cmd.cnt_op = pal_pkg::CNT_DEC;
                    n_state         = S_RESP;
                end else begin
                    o_dp_cmd.ptr_op = pal_pkg::PTR_INC;
                    o_dp_cmd.rd_sel = pal_pkg::RD_PTR;
                end
            end
            S_SW1: begin
                o_dp_cmd.tmp_load = 1'b1;
                o_dp_cmd.rd_sel   = pal_pkg::RD_OPOS;
                n_state           = S_SW2;
            end
            S_SW2: begin
                o_dp_cmd.wr_sel = pal_pkg::WR_POS_RD;
                n_state         = S_SW3;
            end
            S_SW3: begin
                o_dp_cmd.wr_sel = pal_pkg::WR_OPOS_TMP;
                n_state         = S_RESP;
            end
            S_RESP: begin
                // hold until the output register can take the beat
                if (i_dp_stat.out_free) begin
                    o_dp_cmd.out_load = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_status  <= pal_pkg::ST_OK;
            r_rd_flag <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_status  <= n_status;
            r_rd_flag <= n_rd_flag;
        end
    end

endmodule

FILE: hdl/positional_array_list.sv
// Channel     | Dir | Signals                        | Beat contents
// ------------+-----+--------------------------------+------------------------------------------
// command     | in  | s_axis_tvalid/tready/tdata/tuser | tuser: cmd; tdata: position, other_position, value
// result      | out | m_axis_tvalid/tready/tdata     | tdata: read_value, status, length, is_empty
//
// One command at a time. Read, write, clear, errors and an append insert go from the
// execute state straight to the response state; swap first passes S_SW1, S_SW2 and S_SW3.
// Insert at position p shifts the length - p entries from p up, remove at p shifts the length - p - 1 above p down,
// one entry moved per cycle through the single write port of the entry memory.
// Reset empties the list at once; entries are not cleared. A stalled result holds the
// next command in the response state; the command side waits until then.
module positional_array_list #(
    parameter int ENTRY_WIDTH = pal_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [6:0] position, [12:7] other_position, [44:13] value, rest zero
    input  logic [pal_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [2:0] cmd
    input  logic [pal_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] read_value, [33:32] status, [40:34] length, [41] is_empty, rest zero
    output logic [pal_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int OPOS_LO = pal_pkg::POS_W;
    localparam int VAL_LO  = pal_pkg::POS_W + pal_pkg::OPOS_W;

    pal_pkg::t_dp_cmd  dp_cmd;
    pal_pkg::t_dp_stat dp_stat;

    pal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_dp_stat  (dp_stat),
        .o_dp_cmd   (dp_cmd)
    );

    pal_dp #(
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_axis_tuser),
        .i_pos       (s_axis_tdata[pal_pkg::POS_W-1:0]),
        .i_opos      (s_axis_tdata[VAL_LO-1:OPOS_LO]),
        .i_val       (s_axis_tdata[VAL_LO+pal_pkg::VAL_W-1:VAL_LO]),
        .i_dp_cmd    (dp_cmd),
        .o_dp_stat   (dp_stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

FILE: hdl/pal_checker.sv
module pal_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [pal_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    logic [31:0] rd_value;
    logic [1:0]  status;
    logic [6:0]  length;
    logic        is_empty;

    assign rd_value = m_axis_tdata[31:0];
    assign status   = m_axis_tdata[33:32];
    assign length   = m_axis_tdata[40:34];
    assign is_empty = m_axis_tdata[41];

    // a stalled result beat holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (is_empty == (length == 7'd0)))
        else $error("empty flag disagrees with length");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> length <= 7'(pal_pkg::MAX_ENTRIES) && status != 2'd3)
        else $error("length or status out of range");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status != pal_pkg::ST_OK |-> rd_value == 32'd0)
        else $error("failed command returned data");

endmodule

bind positional_array_list pal_checker u_pal_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/sv/positional_array_list_checker.sv
module positional_array_list_checker
    import pal_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    input  logic                   i_cmd_ready,
    // [6:0] position, [12:7] other_position, [44:13] value, rest zero
    input  logic [IN_TDATA_W-1:0]  i_cmd_data,
    // [2:0] cmd
    input  logic [CMD_W-1:0]       i_cmd_kind,
    input  logic                   i_res_valid,
    input  logic                   i_res_ready,
    // [31:0] read_value, [33:32] status, [40:34] length, [41] is_empty, rest zero
    input  logic [OUT_TDATA_W-1:0] i_res_data,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VAL_W-1:0]  read_value;
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  length;
        logic              is_empty;
    } t_reply;

    logic [VAL_W-1:0] list_words [MAX_ENTRIES];
    int               list_len   = 0;
    t_reply           replies_due[$];
    int               fails      = 0;
    int               checked    = 0;

    // Apply one command to the shadow list and return the reply it must produce.
    function automatic t_reply apply_list_cmd(input logic [CMD_W-1:0] cmd,
                                              input logic [POS_W-1:0] pos,
                                              input logic [OPOS_W-1:0] opos,
                                              input logic [VAL_W-1:0] val);
        t_reply           r;
        logic [VAL_W-1:0] held;
        int               i;
        r        = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_READ: begin
                if (pos >= list_len) r.status = ST_RANGE;
                else r.read_value = list_words[pos];
            end
            CMD_WRITE: begin
                if (pos >= list_len) r.status = ST_RANGE;
                else list_words[pos] = val;
            end
            CMD_INSERT: begin
                if (pos > list_len) begin
                    r.status = ST_RANGE;
                end else if (list_len >= MAX_ENTRIES) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
                    list_words[pos] = val;
                    list_len++;
                end
            end
            CMD_REMOVE: begin
                if (pos >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            CMD_SWAP: begin
                if (pos >= list_len || opos >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    held             = list_words[pos];
                    list_words[pos]  = list_words[opos];
                    list_words[opos] = held;
                end
            end
            CMD_CLEAR: list_len = 0;
            default: ;
        endcase
        r.length   = LEN_W'(list_len);
        r.is_empty = (list_len == 0);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            replies_due.delete();
            list_len = 0;
        end else begin
            // retire before predicting: a reply never belongs to the command
            // accepted on the same edge
            if (i_res_valid && i_res_ready) begin
                got.read_value = i_res_data[VAL_W-1:0];
                got.status     = i_res_data[VAL_W +: STAT_W];
                got.length     = i_res_data[VAL_W+STAT_W +: LEN_W];
                got.is_empty   = i_res_data[VAL_W+STAT_W+LEN_W];
                if (replies_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: reply with no command outstanding: value=%h status=%0d",
                                 $realtime, got.read_value, got.status);
                end else begin
                    want = replies_due.pop_front();
                    checked++;
                    if (got.read_value !== want.read_value || got.status !== want.status ||
                        got.length !== want.length || got.is_empty !== want.is_empty) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t: reply %0d mismatch", $realtime, checked);
                            $display("  expected value=%h status=%0d length=%0d empty=%0d",
                                     want.read_value, want.status, want.length, want.is_empty);
                            $display("  actual   value=%h status=%0d length=%0d empty=%0d",
                                     got.read_value, got.status, got.length, got.is_empty);
                        end
                    end
                end
            end
            if (i_cmd_valid && i_cmd_ready)
                replies_due.push_back(apply_list_cmd(i_cmd_kind,
                                                     i_cmd_data[POS_W-1:0],
                                                     i_cmd_data[POS_W +: OPOS_W],
                                                     i_cmd_data[POS_W+OPOS_W +: VAL_W]));
        end
        o_pending    <= replies_due.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

FILE: tb/sv/tb_positional_array_list.sv
module tb_positional_array_list;
    timeunit 1ns;
    timeprecision 1ps;

    import pal_pkg::*;

    // codes outside the command set; the block must ignore them
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    localparam int RANDOM_CMDS    = 630;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES    = 100;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [6:0] position, [12:7] other_position, [44:13] value, rest zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // [2:0] cmd
    logic [CMD_W-1:0]       s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [31:0] read_value, [33:32] status, [40:34] length, [41] is_empty, rest zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;
    int checked;

    bit steady        = 1'b0;
    int hold_requests = 0;
    int list_len      = 0;
    int full_hits     = 0;
    int kind_sent [8] = '{default: 0};

    always #4 i_clk = ~i_clk;

    positional_array_list dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    positional_array_list_checker list_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (s_axis_tvalid),
        .i_cmd_ready  (s_axis_tready),
        .i_cmd_data   (s_axis_tdata),
        .i_cmd_kind   (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Drive one command beat and hold it until accepted.
    task automatic offer_cmd(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                             input logic [OPOS_W-1:0] op, input logic [VAL_W-1:0] v);
        if (!steady) begin
            while ($urandom_range(0, 99) < 16) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-IN_FIELDS_W){1'b0}}, v, op, p};
        s_axis_tuser  <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        kind_sent[c]++;
        // track the length only to steer positions toward valid ones
        case (c)
            CMD_INSERT: begin
                if (p <= list_len && list_len == MAX_ENTRIES) full_hits++;
                if (p <= list_len && list_len < MAX_ENTRIES) list_len++;
            end
            CMD_REMOVE: if (p < list_len) list_len--;
            CMD_CLEAR:  list_len = 0;
            default: ;
        endcase
    endtask

    task automatic offer_random(input int mode, output bit counts);
        int               roll;
        int               t_ins, t_rem, t_rd, t_wr, t_sw, t_clr;
        logic [CMD_W-1:0] c;
        logic [POS_W-1:0] p;
        logic [OPOS_W-1:0] op;
        bit               stray;
        case (mode)
            1:       begin t_ins = 55; t_rem = 65; t_rd = 77; t_wr = 87; t_sw = 97; t_clr = 98; end
            2:       begin t_ins = 15; t_rem = 60; t_rd = 75; t_wr = 85; t_sw = 95; t_clr = 98; end
            default: begin t_ins = 28; t_rem = 52; t_rd = 70; t_wr = 84; t_sw = 96; t_clr = 98; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < t_ins)      c = CMD_INSERT;
        else if (roll < t_rem) c = CMD_REMOVE;
        else if (roll < t_rd)  c = CMD_READ;
        else if (roll < t_wr)  c = CMD_WRITE;
        else if (roll < t_sw)  c = CMD_SWAP;
        else if (roll < t_clr) c = CMD_CLEAR;
        else                   c = roll[0] ? CMD_RSVD7 : CMD_RSVD6;
        stray = ($urandom_range(0, 9) == 0);
        if (c == CMD_INSERT)
            p = stray ? $urandom_range(list_len < MAX_ENTRIES ? list_len + 1 : MAX_ENTRIES,
                                       MAX_ENTRIES)
                      : $urandom_range(0, list_len);
        else if (stray || list_len == 0)
            p = $urandom_range(list_len, MAX_ENTRIES);
        else
            p = $urandom_range(0, list_len - 1);
        if (c == CMD_SWAP && list_len > 0 && $urandom_range(0, 9) != 0)
            op = $urandom_range(0, list_len - 1);
        else
            op = $urandom_range(0, 63);
        offer_cmd(c, p, op, $urandom);
        counts = (c <= CMD_CLEAR);
    endtask

    // Stop offering until every reply has come back.
    task automatic wait_all_replies();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Result side: random backpressure, plus long holds on request.
    initial begin : result_sink
        int holds_done;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 16);
            end
        end
    end

    initial begin : run_limit
        #8ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        int mode;
        int left_in_mode;
        int random_sent;
        bit counts;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: every indexed command is out of range
        offer_cmd(CMD_READ,   0, 0, 32'h0);
        offer_cmd(CMD_REMOVE, 0, 0, 32'h0);
        offer_cmd(CMD_SWAP,   0, 0, 32'h0);
        offer_cmd(CMD_INSERT, 1, 0, 32'hDEAD_BEEF);
        // build A5, FF, 3C, 00 through front, end and middle inserts
        offer_cmd(CMD_INSERT, 0, 0, 32'hFFFF_FFFF);
        offer_cmd(CMD_INSERT, 1, 0, 32'h0000_0000);
        offer_cmd(CMD_INSERT, 0, 0, 32'hA5A5_A5A5);
        offer_cmd(CMD_INSERT, 2, 0, 32'h3C3C_3C3C);
        offer_cmd(CMD_READ,   3, 0, 32'h0);
        offer_cmd(CMD_READ,   2, 63, 32'hFFFF_FFFF);
        offer_cmd(CMD_WRITE,  1, 0, 32'h1234_5678);
        offer_cmd(CMD_WRITE,  64, 0, 32'hFFFF_FFFF);
        offer_cmd(CMD_SWAP,   0, 3, 32'h0);
        offer_cmd(CMD_SWAP,   1, 1, 32'h0);
        offer_cmd(CMD_SWAP,   3, 4, 32'h0);
        offer_cmd(CMD_REMOVE, 3, 0, 32'h0);
        offer_cmd(CMD_REMOVE, 0, 0, 32'h0);
        offer_cmd(CMD_READ,   0, 0, 32'h0);
        offer_cmd(CMD_READ,   1, 0, 32'h0);
        offer_cmd(CMD_READ,   4, 0, 32'h0);
        offer_cmd(CMD_RSVD6,  1, 5, 32'h5555_AAAA);
        offer_cmd(CMD_RSVD7,  64, 63, 32'hAAAA_5555);
        offer_cmd(CMD_CLEAR,  0, 0, 32'h0);
        offer_cmd(CMD_READ,   0, 0, 32'h0);
        offer_cmd(CMD_INSERT, 0, 0, 32'h8000_0001);
        offer_cmd(CMD_REMOVE, 0, 0, 32'h0);
        wait_all_replies();

        // fill to capacity without gaps, then probe the full list
        steady = 1'b1;
        while (list_len < MAX_ENTRIES)
            offer_cmd(CMD_INSERT, $urandom_range(0, list_len), $urandom_range(0, 63), $urandom);
        offer_cmd(CMD_INSERT, 64, 0, $urandom);
        offer_cmd(CMD_INSERT, 0, 0, $urandom);
        offer_cmd(CMD_SWAP,   0, 63, 32'h0);
        offer_cmd(CMD_SWAP,   63, 0, 32'h0);
        offer_cmd(CMD_READ,   63, 0, 32'h0);
        offer_cmd(CMD_READ,   64, 0, 32'h0);
        // hold the result side while long removes keep coming
        hold_requests++;
        repeat (12) offer_cmd(CMD_REMOVE, $urandom_range(0, 3), $urandom_range(0, 63), $urandom);
        steady = 1'b0;

        mode         = 0;
        left_in_mode = 0;
        random_sent  = 0;
        while (random_sent < RANDOM_CMDS) begin
            if (left_in_mode == 0) begin
                mode         = $urandom_range(0, 2);
                left_in_mode = $urandom_range(40, 80);
                steady       = ($urandom_range(0, 5) == 0);
            end
            left_in_mode--;
            if (random_sent == 300 && counts) hold_requests++;
            if (random_sent == 500 && counts) wait_all_replies();
            offer_random(mode, counts);
            if (counts) random_sent++;
        end

        wait_all_replies();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Run: %0d inserts (%0d into a full list), %0d removes, %0d reads,",
                 kind_sent[CMD_INSERT], full_hits, kind_sent[CMD_REMOVE], kind_sent[CMD_READ]);
        $display("     %0d writes, %0d swaps, %0d clears, %0d spare codes; %0d replies checked",
                 kind_sent[CMD_WRITE], kind_sent[CMD_SWAP], kind_sent[CMD_CLEAR],
                 kind_sent[CMD_RSVD6] + kind_sent[CMD_RSVD7], checked);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/pal_pkg.sv
hdl/pal_dp.sv
hdl/pal_ctrl.sv
hdl/positional_array_list.sv
hdl/pal_checker.sv
tb/sv/positional_array_list_checker.sv
tb/sv/tb_positional_array_list.sv
